### hdl/lidar_point_projector_colorizer_core_assert.svh
// assertion macros used by the projector core
`ifndef LIDAR_POINT_PROJECTOR_COLORIZER_CORE_ASSERT_SVH
`define LIDAR_POINT_PROJECTOR_COLORIZER_CORE_ASSERT_SVH

// condition implies consequence in the same cycle
`define LPPC_ASSERT_IMPL(label, clk_sig, rst_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
		else $error("lppc assertion failed");

// condition excludes the given expression in the same cycle
`define LPPC_ASSERT_NOT(label, clk_sig, rst_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> !(cons)) \
		else $error("lppc assertion failed");

`endif

### hdl/lppc_pkg.sv
// shared constants and types of the point projector
package lppc_pkg;

	localparam int COORD_WIDTH_DEF = 24;
	localparam int COEF_WIDTH_DEF = 32;
	localparam int CFG_WIDTH = 64;
	localparam int CFG_IDX_WIDTH = 3;
	localparam int ACC_WIDTH = 64;
	localparam int LIMIT_WIDTH = 23;
	localparam int PIX_WIDTH = 16;
	localparam int COLOR_WIDTH = 8;
	localparam int Q_BITS = PIX_WIDTH;
	localparam int DIV_WIDTH = 83;

	localparam int MM_STAGES = 4;
	localparam int RD_STAGES = Q_BITS + 1;
	localparam int CL_STAGES = COLOR_WIDTH + 2;
	localparam int COLOR_LAG = MM_STAGES + RD_STAGES - CL_STAGES;

	localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW0_A = 3'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW0_B = 3'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW1_A = 3'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW1_B = 3'd3;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW2_A = 3'd4;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW2_B = 3'd5;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_NEAR = 3'd6;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_FAR = 3'd7;

	localparam logic [LIMIT_WIDTH-1:0] NEAR_RESET = 23'd500;
	localparam logic [LIMIT_WIDTH-1:0] FAR_RESET = 23'd130000;
	localparam logic [COLOR_WIDTH-1:0] COLOR_FULL = 8'hff;

	typedef struct packed {
		logic valid;
		logic behind;
		logic signed [ACC_WIDTH-1:0] a0;
		logic signed [ACC_WIDTH-1:0] a1;
		logic signed [ACC_WIDTH-1:0] a2;
	} proj_acc_t;

	typedef struct packed {
		logic valid;
		logic behind;
	} proj_ctl_t;

endpackage

### hdl/lppc_matmul.sv
// matrix times point, saturating row sums over four stages
module lppc_matmul #(
	parameter int COORD_WIDTH = lppc_pkg::COORD_WIDTH_DEF,
	parameter int COEF_WIDTH = lppc_pkg::COEF_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic signed [COORD_WIDTH-1:0] x,
	input  logic signed [COORD_WIDTH-1:0] y,
	input  logic signed [COORD_WIDTH-1:0] z,
	input  logic [lppc_pkg::CFG_WIDTH-1:0] pair_a [3],
	input  logic [lppc_pkg::CFG_WIDTH-1:0] pair_b [3],
	output lppc_pkg::proj_acc_t acc
);
	import lppc_pkg::*;

	localparam int PW = COORD_WIDTH + COEF_WIDTH;

	logic signed [COEF_WIDTH-1:0] c [3][4];
	logic signed [PW-1:0] prod [3][3];
	logic signed [PW-1:0] p_s1 [3][3];
	logic signed [ACC_WIDTH-1:0] sum_s2 [3];
	logic signed [PW-1:0] p2_s2 [3];
	logic signed [ACC_WIDTH-1:0] sum_s3 [3];
	logic signed [ACC_WIDTH-1:0] fin [3];
	logic signed [ACC_WIDTH-1:0] acc_s4 [3];
	logic behind_s4;
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	function automatic logic signed [ACC_WIDTH-1:0] sat64(input logic signed [ACC_WIDTH:0] v);
		logic signed [ACC_WIDTH-1:0] r;
		if (v[ACC_WIDTH] != v[ACC_WIDTH-1]) begin
			r = v[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}} : {1'b0, {(ACC_WIDTH-1){1'b1}}};
		end else begin
			r = v[ACC_WIDTH-1:0];
		end
		return r;
	endfunction

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			c[r][0] = $signed(pair_a[r][32 +: COEF_WIDTH]);
			c[r][1] = $signed(pair_a[r][0 +: COEF_WIDTH]);
			c[r][2] = $signed(pair_b[r][32 +: COEF_WIDTH]);
			c[r][3] = $signed(pair_b[r][0 +: COEF_WIDTH]);
			prod[r][0] = c[r][0] * x;
			prod[r][1] = c[r][1] * y;
			prod[r][2] = c[r][2] * z;
			fin[r] = sat64((ACC_WIDTH+1)'(sum_s3[r]) + (ACC_WIDTH+1)'(c[r][3]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				p_s1[r][k] <= prod[r][k];
			end
			sum_s2[r] <= sat64((ACC_WIDTH+1)'(p_s1[r][0]) + (ACC_WIDTH+1)'(p_s1[r][1]));
			p2_s2[r] <= p_s1[r][2];
			sum_s3[r] <= sat64((ACC_WIDTH+1)'(sum_s2[r]) + (ACC_WIDTH+1)'(p2_s2[r]));
			acc_s4[r] <= fin[r];
		end
		behind_s4 <= (fin[2] <= 0);
	end

	assign acc.valid = valid_s4;
	assign acc.behind = behind_s4;
	assign acc.a0 = acc_s4[0];
	assign acc.a1 = acc_s4[1];
	assign acc.a2 = acc_s4[2];

endmodule

### hdl/lppc_rdiv.sv
// pipelined rounding divide with 16-bit saturation, one quotient bit per stage
module lppc_rdiv (
	input  logic clk,
	input  logic signed [lppc_pkg::ACC_WIDTH-1:0] num,
	input  logic signed [lppc_pkg::ACC_WIDTH-1:0] den,
	output logic signed [lppc_pkg::PIX_WIDTH-1:0] quo,
	output logic sat
);
	import lppc_pkg::*;

	logic [DIV_WIDTH-1:0] rem_s [Q_BITS+1];
	logic [DIV_WIDTH-1:0] dd_s [Q_BITS+1];
	logic [Q_BITS-1:0] q_s [Q_BITS+1];
	logic hi_s [Q_BITS+1];
	logic lo_s [Q_BITS+1];
	logic [Q_BITS-1:0] qf;

	// offset numerator: 2a + d + 65536 d, divisor 2d
	always_ff @(posedge clk) begin
		rem_s[0] <= (DIV_WIDTH'(num) <<< 1) + DIV_WIDTH'(den) + (DIV_WIDTH'(den) <<< 16);
		dd_s[0] <= DIV_WIDTH'(den) <<< 1;
		q_s[0] <= '0;
		hi_s[0] <= 1'b0;
		lo_s[0] <= 1'b0;
	end

	for (genvar k = 0; k < Q_BITS; k++) begin : g_step
		localparam int B = Q_BITS - 1 - k;
		logic [DIV_WIDTH-1:0] sub;
		logic take;
		assign sub = dd_s[k] << B;
		assign take = rem_s[k] >= sub;
		always_ff @(posedge clk) begin
			rem_s[k+1] <= take ? rem_s[k] - sub : rem_s[k];
			dd_s[k+1] <= dd_s[k];
			q_s[k+1] <= {q_s[k][Q_BITS-2:0], take};
			if (k == 0) begin
				hi_s[k+1] <= $signed(rem_s[k]) >= $signed(dd_s[k] << Q_BITS);
				lo_s[k+1] <= rem_s[k][DIV_WIDTH-1];
			end else begin
				hi_s[k+1] <= hi_s[k];
				lo_s[k+1] <= lo_s[k];
			end
		end
	end

	assign qf = q_s[Q_BITS];

	always_comb begin
		if (hi_s[Q_BITS]) begin
			quo = {1'b0, {(PIX_WIDTH-1){1'b1}}};
		end else if (lo_s[Q_BITS]) begin
			quo = {1'b1, {(PIX_WIDTH-1){1'b0}}};
		end else begin
			quo = {~qf[Q_BITS-1], qf[Q_BITS-2:0]};
		end
		sat = hi_s[Q_BITS] | lo_s[Q_BITS];
	end

endmodule

### hdl/lppc_color.sv
// jet color map: segment pick, ramp scaling and 8-stage ramp divide
module lppc_color #(
	parameter int COORD_WIDTH = lppc_pkg::COORD_WIDTH_DEF
) (
	input  logic clk,
	input  logic signed [COORD_WIDTH-1:0] x,
	input  logic [lppc_pkg::LIMIT_WIDTH-1:0] near_mm,
	input  logic [lppc_pkg::LIMIT_WIDTH-1:0] far_mm,
	output logic [lppc_pkg::COLOR_WIDTH-1:0] red,
	output logic [lppc_pkg::COLOR_WIDTH-1:0] green,
	output logic [lppc_pkg::COLOR_WIDTH-1:0] blue
);
	import lppc_pkg::*;

	localparam int TW = ((COORD_WIDTH > LIMIT_WIDTH + 1) ? COORD_WIDTH : LIMIT_WIDTH + 1) + 1;
	localparam int CW = TW + 4;
	localparam int DW = LIMIT_WIDTH + 1;
	localparam int POS_W = DW + 2;
	localparam int RW = POS_W + 9;

	typedef enum logic [2:0] {
		SEG_BELOW, SEG_0, SEG_1, SEG_2, SEG_3, SEG_4, SEG_ABOVE
	} seg_t;

	logic signed [TW-1:0] t;
	logic signed [CW-1:0] t10, dd;
	logic signed [DW-1:0] d;
	seg_t seg;
	logic signed [CW-1:0] t10_s1, d_s1;
	seg_t seg_s1;
	logic signed [CW-1:0] diff;
	logic [POS_W-1:0] pos, span;
	logic [RW-1:0] rem_s [COLOR_WIDTH+1];
	logic [POS_W-1:0] span_s [COLOR_WIDTH+1];
	logic [COLOR_WIDTH-1:0] q_s [COLOR_WIDTH+1];
	seg_t seg_s [COLOR_WIDTH+1];
	logic [COLOR_WIDTH-1:0] rmp;

	always_comb begin
		t = TW'(x) - TW'($signed({1'b0, near_mm}));
		d = $signed({1'b0, far_mm}) - $signed({1'b0, near_mm});
		t10 = (CW'(t) <<< 3) + (CW'(t) <<< 1);
		dd = CW'(d);
		if (t < 0) begin
			seg = SEG_BELOW;
		end else if (t10 < dd) begin
			seg = SEG_0;
		end else if (t10 < (dd <<< 1)) begin
			seg = SEG_1;
		end else if (t10 < (dd <<< 2)) begin
			seg = SEG_2;
		end else if (t10 < (dd <<< 3) - dd) begin
			seg = SEG_3;
		end else if (t10 < (dd <<< 3) + (dd <<< 1)) begin
			seg = SEG_4;
		end else begin
			seg = SEG_ABOVE;
		end
	end

	always_ff @(posedge clk) begin
		t10_s1 <= t10;
		d_s1 <= dd;
		seg_s1 <= seg;
	end

	// position and width of the active ramp
	always_comb begin
		diff = t10_s1;
		span = POS_W'(d_s1);
		unique case (seg_s1)
			SEG_0: begin
				diff = t10_s1;
				span = POS_W'(d_s1);
			end
			SEG_1: begin
				diff = t10_s1 - d_s1;
				span = POS_W'(d_s1);
			end
			SEG_2: begin
				diff = t10_s1 - (d_s1 <<< 1);
				span = POS_W'(d_s1 <<< 1);
			end
			SEG_3: begin
				diff = t10_s1 - (d_s1 <<< 2);
				span = POS_W'((d_s1 <<< 1) + d_s1);
			end
			SEG_4: begin
				diff = t10_s1 - (d_s1 <<< 3) + d_s1;
				span = POS_W'((d_s1 <<< 1) + d_s1);
			end
			default: begin
				diff = '0;
				span = POS_W'(1);
			end
		endcase
		pos = diff[POS_W-1:0];
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= (RW'(pos) << 8) - RW'(pos);
		span_s[0] <= span;
		q_s[0] <= '0;
		seg_s[0] <= seg_s1;
	end

	for (genvar k = 0; k < COLOR_WIDTH; k++) begin : g_step
		localparam int B = COLOR_WIDTH - 1 - k;
		logic [RW-1:0] sub;
		logic take;
		assign sub = RW'(span_s[k]) << B;
		assign take = rem_s[k] >= sub;
		always_ff @(posedge clk) begin
			rem_s[k+1] <= take ? rem_s[k] - sub : rem_s[k];
			span_s[k+1] <= span_s[k];
			q_s[k+1] <= {q_s[k][COLOR_WIDTH-2:0], take};
			seg_s[k+1] <= seg_s[k];
		end
	end

	assign rmp = q_s[COLOR_WIDTH];

	always_comb begin
		unique case (seg_s[COLOR_WIDTH])
			SEG_BELOW: begin
				red = '0; green = '0; blue = COLOR_FULL;
			end
			SEG_0: begin
				red = '0; green = rmp; blue = COLOR_FULL;
			end
			SEG_1: begin
				red = '0; green = COLOR_FULL; blue = COLOR_FULL - rmp;
			end
			SEG_2: begin
				red = rmp; green = COLOR_FULL; blue = '0;
			end
			SEG_3: begin
				red = COLOR_FULL; green = COLOR_FULL - rmp; blue = '0;
			end
			SEG_4: begin
				red = COLOR_FULL; green = '0; blue = rmp;
			end
			default: begin
				red = COLOR_FULL; green = '0; blue = COLOR_FULL;
			end
		endcase
	end

endmodule

### hdl/lidar_point_projector_colorizer_core.sv
// top level: config registers, projection and color pipelines, result register
// Projects lidar points into a camera image and colors them by range.
// Input: raise start with point_x_mm, point_y_mm, point_z_mm; a word is taken
// at each rising edge where start is high and busy is low. busy is high during
// reset and until the first clock edge after it, so one point can be taken
// every cycle after that.
// Output: done is high for one cycle with pixel_u, pixel_v, the color, and the
// behind_camera and coord_saturated flags; results come out in order, one
// result per point.
// Each point passes the four-stage multiply and saturating sum and then
// the 17-stage divider that forms one quotient bit per stage for u and v;
// the color path runs beside it and is delayed to match.
// Configuration: cfg_we with cfg_index and cfg_wdata writes one register in
// the same edge; write only when no points are in flight.
// Reset clears the pipeline valid bits, sets the matrix to zero and the near
// and far limits to 500 and 130000 mm. The receiver cannot stall: results
// are shown for exactly one cycle.
module lidar_point_projector_colorizer_core #(
	parameter int COORD_WIDTH = lppc_pkg::COORD_WIDTH_DEF,
	parameter int COEF_WIDTH = lppc_pkg::COEF_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [COORD_WIDTH-1:0] point_x_mm,
	input  logic signed [COORD_WIDTH-1:0] point_y_mm,
	input  logic signed [COORD_WIDTH-1:0] point_z_mm,
	input  logic cfg_we,
	input  logic [lppc_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [lppc_pkg::CFG_WIDTH-1:0] cfg_wdata,
	output logic done,
	output logic signed [lppc_pkg::PIX_WIDTH-1:0] pixel_u,
	output logic signed [lppc_pkg::PIX_WIDTH-1:0] pixel_v,
	output logic [lppc_pkg::COLOR_WIDTH-1:0] color_red,
	output logic [lppc_pkg::COLOR_WIDTH-1:0] color_green,
	output logic [lppc_pkg::COLOR_WIDTH-1:0] color_blue,
	output logic behind_camera,
	output logic coord_saturated
);
	import lppc_pkg::*;

	`include "lidar_point_projector_colorizer_core_assert.svh"

	logic [CFG_WIDTH-1:0] pair_a_q [3];
	logic [CFG_WIDTH-1:0] pair_b_q [3];
	logic [LIMIT_WIDTH-1:0] near_q, far_q;
	logic busy_q;
	logic accept;
	proj_acc_t acc;
	proj_ctl_t ctl_s [RD_STAGES];
	logic signed [PIX_WIDTH-1:0] u_quo, v_quo;
	logic u_sat, v_sat;
	logic [COLOR_WIDTH-1:0] red_c, green_c, blue_c;
	logic [3*COLOR_WIDTH-1:0] rgb_s [COLOR_LAG];
	logic done_q;
	logic signed [PIX_WIDTH-1:0] pixel_u_q, pixel_v_q;
	logic [3*COLOR_WIDTH-1:0] rgb_q;
	logic behind_q, sat_q;

	assign accept = start & ~busy_q;
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			for (int r = 0; r < 3; r++) begin
				pair_a_q[r] <= '0;
				pair_b_q[r] <= '0;
			end
			near_q <= NEAR_RESET;
			far_q <= FAR_RESET;
		end else begin
			busy_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ROW0_A: pair_a_q[0] <= cfg_wdata;
					REG_ROW0_B: pair_b_q[0] <= cfg_wdata;
					REG_ROW1_A: pair_a_q[1] <= cfg_wdata;
					REG_ROW1_B: pair_b_q[1] <= cfg_wdata;
					REG_ROW2_A: pair_a_q[2] <= cfg_wdata;
					REG_ROW2_B: pair_b_q[2] <= cfg_wdata;
					REG_NEAR: near_q <= cfg_wdata[LIMIT_WIDTH-1:0];
					REG_FAR: far_q <= cfg_wdata[LIMIT_WIDTH-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	lppc_matmul #(
		.COORD_WIDTH(COORD_WIDTH),
		.COEF_WIDTH(COEF_WIDTH)
	) u_matmul (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(accept),
		.x(point_x_mm),
		.y(point_y_mm),
		.z(point_z_mm),
		.pair_a(pair_a_q),
		.pair_b(pair_b_q),
		.acc(acc)
	);

	lppc_rdiv u_div_u (
		.clk(clk),
		.num(acc.a0),
		.den(acc.a2),
		.quo(u_quo),
		.sat(u_sat)
	);

	lppc_rdiv u_div_v (
		.clk(clk),
		.num(acc.a1),
		.den(acc.a2),
		.quo(v_quo),
		.sat(v_sat)
	);

	lppc_color #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_color (
		.clk(clk),
		.x(point_x_mm),
		.near_mm(near_q),
		.far_mm(far_q),
		.red(red_c),
		.green(green_c),
		.blue(blue_c)
	);

	// valid and behind flag ride alongside the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RD_STAGES; i++) begin
				ctl_s[i] <= '0;
			end
		end else begin
			ctl_s[0] <= '{valid: acc.valid, behind: acc.behind};
			for (int i = 1; i < RD_STAGES; i++) begin
				ctl_s[i] <= ctl_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		rgb_s[0] <= {red_c, green_c, blue_c};
		for (int i = 1; i < COLOR_LAG; i++) begin
			rgb_s[i] <= rgb_s[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_s[RD_STAGES-1].valid;
		end
	end

	always_ff @(posedge clk) begin
		behind_q <= ctl_s[RD_STAGES-1].behind;
		pixel_u_q <= ctl_s[RD_STAGES-1].behind ? '0 : u_quo;
		pixel_v_q <= ctl_s[RD_STAGES-1].behind ? '0 : v_quo;
		sat_q <= ~ctl_s[RD_STAGES-1].behind & (u_sat | v_sat);
		rgb_q <= rgb_s[COLOR_LAG-1];
	end

	assign done = done_q;
	assign pixel_u = pixel_u_q;
	assign pixel_v = pixel_v_q;
	assign color_red = rgb_q[3*COLOR_WIDTH-1 -: COLOR_WIDTH];
	assign color_green = rgb_q[2*COLOR_WIDTH-1 -: COLOR_WIDTH];
	assign color_blue = rgb_q[COLOR_WIDTH-1:0];
	assign behind_camera = behind_q;
	assign coord_saturated = sat_q;

	`LPPC_ASSERT_IMPL(a_behind_zero, clk, arst_n, done && behind_camera, pixel_u == '0 && pixel_v == '0 && !coord_saturated)
	`LPPC_ASSERT_IMPL(a_sat_limit, clk, arst_n, done && coord_saturated, pixel_u == 16'sh7fff || pixel_u == 16'sh8000 || pixel_v == 16'sh7fff || pixel_v == 16'sh8000)
	`LPPC_ASSERT_IMPL(a_blue_side, clk, arst_n, done && color_red == '0 && color_green != COLOR_FULL, color_blue == COLOR_FULL)
	`LPPC_ASSERT_NOT(a_magenta_end, clk, arst_n, done && color_red == COLOR_FULL && color_blue == COLOR_FULL, color_green != '0)

endmodule

### sim/lidar_point_projector_colorizer_core_test.sv
// self-checking testbench of the lidar point projector and colorizer core
module lidar_point_projector_colorizer_core_test;
	import lppc_pkg::*;

	typedef struct packed {
		logic signed [15:0] u;
		logic signed [15:0] v;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic behind;
		logic sat;
	} pixel_word_t;

	localparam int LATENCY = 22;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [23:0] point_x_mm;
	logic signed [23:0] point_y_mm;
	logic signed [23:0] point_z_mm;
	logic cfg_we;
	logic [CFG_IDX_WIDTH-1:0] cfg_index;
	logic [CFG_WIDTH-1:0] cfg_wdata;
	logic done;
	logic signed [15:0] pixel_u;
	logic signed [15:0] pixel_v;
	logic [7:0] color_red;
	logic [7:0] color_green;
	logic [7:0] color_blue;
	logic behind_camera;
	logic coord_saturated;

	logic [63:0] matrix_pair [0:5];
	longint near_mm;
	longint far_mm;
	pixel_word_t want_ring [64];
	int sent_total;
	int checked_total;
	int error_count;
	int idle_cycles;

	lidar_point_projector_colorizer_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.point_x_mm(point_x_mm), .point_y_mm(point_y_mm), .point_z_mm(point_z_mm),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.done(done), .pixel_u(pixel_u), .pixel_v(pixel_v),
		.color_red(color_red), .color_green(color_green), .color_blue(color_blue),
		.behind_camera(behind_camera), .coord_saturated(coord_saturated)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// wide signed math so saturation at 64 bits is exact
	function automatic longint sat_sum(longint a, longint b);
		logic signed [65:0] s;
		s = 66'(signed'(a)) + 66'(signed'(b));
		if (s > 66'sh7fffffffffffffff)
			return 64'sh7fffffffffffffff;
		if (s < -66'sh8000000000000000)
			return 64'sh8000000000000000;
		return longint'(s);
	endfunction

	function automatic longint row_depth(int r, longint x, longint y, longint z);
		longint c0, c1, c2, c3, s;
		c0 = longint'($signed(matrix_pair[2*r][63:32]));
		c1 = longint'($signed(matrix_pair[2*r][31:0]));
		c2 = longint'($signed(matrix_pair[2*r+1][63:32]));
		c3 = longint'($signed(matrix_pair[2*r+1][31:0]));
		s = sat_sum(c0 * x, c1 * y);
		s = sat_sum(s, c2 * z);
		return sat_sum(s, c3);
	endfunction

	function automatic logic signed [15:0] round_pixel(longint a, longint d, inout logic sat);
		logic signed [65:0] q, r;
		q = 66'(signed'(a)) / 66'(signed'(d));
		r = 66'(signed'(a)) % 66'(signed'(d));
		if (r < 0) begin
			q = q - 1;
			r = r + d;
		end
		if (r >= d - r)
			q = q + 1;
		if (q > 32767) begin
			sat = 1'b1;
			return 16'sh7fff;
		end
		if (q < -32768) begin
			sat = 1'b1;
			return 16'sh8000;
		end
		return q[15:0];
	endfunction

	function automatic logic [7:0] ramp(longint pos, longint span);
		if (span <= 0 || pos <= 0)
			return 8'd0;
		return 8'((pos * 255) / span);
	endfunction

	function automatic pixel_word_t project_point(logic [23:0] px, logic [23:0] py,
			logic [23:0] pz);
		pixel_word_t w;
		longint x, y, z, a0, a1, a2, t, d, t10;
		x = longint'($signed(px));
		y = longint'($signed(py));
		z = longint'($signed(pz));
		a0 = row_depth(0, x, y, z);
		a1 = row_depth(1, x, y, z);
		a2 = row_depth(2, x, y, z);
		w = '0;
		w.behind = (a2 <= 0);
		if (!w.behind) begin
			w.u = round_pixel(a0, a2, w.sat);
			w.v = round_pixel(a1, a2, w.sat);
		end
		t = x - near_mm;
		d = far_mm - near_mm;
		t10 = t * 10;
		if (t < 0) begin
			w.blue = 8'hff;
		end else if (t10 < d) begin
			w.green = ramp(t10, d);
			w.blue = 8'hff;
		end else if (t10 < 2 * d) begin
			w.green = 8'hff;
			w.blue = 8'hff - ramp(t10 - d, d);
		end else if (t10 < 4 * d) begin
			w.red = ramp(t10 - 2 * d, 2 * d);
			w.green = 8'hff;
		end else if (t10 < 7 * d) begin
			w.red = 8'hff;
			w.green = 8'hff - ramp(t10 - 4 * d, 3 * d);
		end else if (t10 < 10 * d) begin
			w.red = 8'hff;
			w.blue = ramp(t10 - 7 * d, 3 * d);
		end else begin
			w.red = 8'hff;
			w.blue = 8'hff;
		end
		return w;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	always @(posedge clk) begin
		pixel_word_t want;
		if (arst_n && done) begin
			if (checked_total == sent_total) begin
				report_mismatch("unexpected word", 1, 0);
			end else begin
				want = want_ring[6'(checked_total)];
				checked_total++;
				if (pixel_u !== want.u) report_mismatch("pixel_u", pixel_u, want.u);
				if (pixel_v !== want.v) report_mismatch("pixel_v", pixel_v, want.v);
				if (color_red !== want.red) report_mismatch("color_red", color_red, want.red);
				if (color_green !== want.green)
					report_mismatch("color_green", color_green, want.green);
				if (color_blue !== want.blue)
					report_mismatch("color_blue", color_blue, want.blue);
				if (behind_camera !== want.behind)
					report_mismatch("behind_camera", behind_camera, want.behind);
				if (coord_saturated !== want.sat)
					report_mismatch("coord_saturated", coord_saturated, want.sat);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("lidar_point_projector_colorizer_core regression: fail");
			$finish;
		end
	end

	function automatic int gap_length();
		int n;
		n = $urandom_range(0, 99);
		if (n < 55) n = 0;
		else if (n < 92) n = $urandom_range(1, 3);
		else n = $urandom_range(5, 40);
		return n;
	endfunction

	task automatic send_point(logic [23:0] x, logic [23:0] y, logic [23:0] z);
		int gap;
		start <= 1'b1;
		point_x_mm <= x;
		point_y_mm <= y;
		point_z_mm <= z;
		@(posedge clk);
		while (busy) @(posedge clk);
		want_ring[6'(sent_total)] = project_point(x, y, z);
		sent_total++;
		gap = ($urandom_range(0, 3) != 0) ? gap_length() : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (checked_total != sent_total) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [63:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_NEAR) near_mm = longint'(data[22:0]);
		else if (idx == REG_FAR) far_mm = longint'(data[22:0]);
		else matrix_pair[idx] = data;
		@(posedge clk);
	endtask

	function automatic logic [31:0] small_coef();
		return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
	endfunction

	function automatic logic [23:0] any_coord();
		case ($urandom_range(0, 3))
			0: return 24'($signed($urandom_range(0, 400000)) - 200000);
			1: return 24'($urandom());
			2: return ($urandom_range(0, 1)) ? 24'h7fffff : 24'h800000;
			default: return 24'($urandom_range(0, 140000));
		endcase
	endfunction

	task automatic load_camera();
		// plausible intrinsics and a mostly forward-looking depth row
		write_reg(REG_ROW0_A, {32'(600 << 16) + small_coef(), small_coef()});
		write_reg(REG_ROW0_B, {small_coef(), $urandom()});
		write_reg(REG_ROW1_A, {small_coef(), 32'(600 << 16) + small_coef()});
		write_reg(REG_ROW1_B, {small_coef(), $urandom()});
		write_reg(REG_ROW2_A, {32'(1 << 16), 32'($signed($urandom_range(0, 512)) - 256)});
		write_reg(REG_ROW2_B, {32'($signed($urandom_range(0, 512)) - 256),
			32'($urandom_range(0, 1 << 20))});
	endtask

	task automatic test_reset_defaults();
		send_point(24'd1000, 24'd5, 24'd5);
		send_point(24'h800000, 24'h7fffff, 24'h800000);
		drain();
	endtask

	task automatic test_directed_corners();
		load_camera();
		write_reg(REG_NEAR, 64'd500);
		write_reg(REG_FAR, 64'd10500);
		send_point(24'd499, 24'd0, 24'd0);
		send_point(24'd500, 24'd0, 24'd0);
		send_point(24'd1499, 24'd100, 24'd0);
		send_point(24'd1500, 24'd0, 24'd100);
		send_point(24'd2500, 24'd0, 24'd0);
		send_point(24'd4500, 24'd0, 24'd0);
		send_point(24'd7500, 24'd0, 24'd0);
		send_point(24'd10499, 24'd0, 24'd0);
		send_point(24'd10500, 24'd0, 24'd0);
		send_point(24'd5, 24'd9000, 24'd9000);
		send_point(24'h7fffff, 24'h7fffff, 24'h7fffff);
		send_point(24'h800000, 24'h800000, 24'h800000);
		send_point(-24'sd5000, 24'd0, 24'd0);
		drain();
		// exact zero depth and half-way rounding
		write_reg(REG_ROW0_A, {32'h0000_8000, 32'd0});
		write_reg(REG_ROW0_B, 64'd0);
		write_reg(REG_ROW1_A, {32'hffff_8000, 32'd0});
		write_reg(REG_ROW1_B, 64'd0);
		write_reg(REG_ROW2_A, {32'h0001_0000, 32'd0});
		write_reg(REG_ROW2_B, 64'd0);
		send_point(24'd0, 24'd0, 24'd0);
		send_point(24'd1, 24'd0, 24'd0);
		send_point(24'd3, 24'd0, 24'd0);
		send_point(-24'sd1, 24'd0, 24'd0);
		drain();
		// far not above near, and extreme limits
		write_reg(REG_NEAR, 64'h7fffff);
		write_reg(REG_FAR, 64'd1);
		send_point(24'h7ffffe, 24'd0, 24'd0);
		send_point(24'h7fffff, 24'd0, 24'd0);
		drain();
		write_reg(REG_NEAR, 64'd0);
		write_reg(REG_FAR, 64'h7fffff);
		send_point(24'h7fffff, 24'd0, 24'd0);
		send_point(24'd0, 24'd0, 24'd0);
		drain();
	endtask

	task automatic test_random_phase(int count, bit wide_matrix);
		int i;
		if (wide_matrix) begin
			for (i = 0; i < 6; i++)
				write_reg(3'(i), {$urandom(), $urandom()});
		end else begin
			load_camera();
		end
		write_reg(REG_NEAR, 64'($urandom_range(0, 20000)));
		write_reg(REG_FAR, (($urandom_range(0, 7) == 0) ? 64'($urandom()) :
			64'($urandom_range(20000, 200000))));
		for (i = 0; i < count; i++)
			send_point(any_coord(), any_coord(), any_coord());
		drain();
	endtask

	initial begin
		int p;
		arst_n = 1'b0;
		start = 1'b0;
		point_x_mm = '0;
		point_y_mm = '0;
		point_z_mm = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		error_count = 0;
		idle_cycles = 0;
		sent_total = 0;
		checked_total = 0;
		for (p = 0; p < 6; p++) matrix_pair[p] = '0;
		near_mm = longint'(NEAR_RESET);
		far_mm = longint'(FAR_RESET);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed_corners();
		for (p = 0; p < 10; p++)
			test_random_phase(110, (p % 4) == 3);
		drain();
		repeat (LATENCY + 8) @(posedge clk);
		if (error_count == 0)
			$display("lidar_point_projector_colorizer_core regression: pass");
		else
			$display("lidar_point_projector_colorizer_core regression: fail");
		$finish;
	end

endmodule
